// ===== rtl/core/ifht_pkg.sv =====
// ifht_pkg: shared constants and control/status types of the hole tracker
// used by every module of the hole tracker; depends on nothing else
package ifht_pkg;

  localparam int unsigned MAX_HOLES_DEF = 8;
  localparam int unsigned START_W       = 17;
  localparam int unsigned END_W         = 18;
  localparam int unsigned OFS_W         = 16;

  localparam logic [END_W-1:0] HOLE_INF = {END_W{1'b1}};

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_FRAG  = 1'b1;

  typedef struct packed {
    logic load;
    logic scan;
    logic split;
  } cmd_t;

  typedef struct packed {
    logic need_split;
    logic scan_done;
    logic more_needed;
    logic table_full;
  } sts_t;

endpackage

// ===== rtl/core/ifht_ctrl.sv =====
// ifht_ctrl: sequencer of the hole tracker, drives load, scan and split steps
// depends on ifht_pkg
module ifht_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  ifht_pkg::sts_t  sts_i,
  output ifht_pkg::cmd_t  cmd_o,
  output logic            busy_o,
  output logic            done_o,
  output logic            more_needed_o,
  output logic            table_full_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SPLIT
  } state_e;

  state_e state_q;
  logic   done_q;
  logic   more_q;
  logic   full_q;

  always_comb begin
    cmd_o.load  = (state_q == ST_IDLE) && start_i;
    cmd_o.scan  = (state_q == ST_SCAN);
    cmd_o.split = (state_q == ST_SPLIT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      more_q  <= 1'b0;
      full_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (sts_i.need_split) begin
            state_q <= ST_SPLIT;
          end else if (sts_i.scan_done) begin
            state_q <= ST_IDLE;
            done_q  <= 1'b1;
            more_q  <= sts_i.more_needed;
            full_q  <= sts_i.table_full;
          end
        end
        ST_SPLIT: begin
          state_q <= ST_SCAN;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign more_needed_o = more_q;
  assign table_full_o  = full_q;

endmodule

// ===== rtl/core/ifht_dp.sv =====
// ifht_dp: hole table memories, in-use bits and the per-entry overlap datapath
// depends on ifht_pkg
module ifht_dp #(
  parameter int unsigned MAX_HOLES = ifht_pkg::MAX_HOLES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ifht_pkg::cmd_t              cmd_i,
  input  logic                        kind_i,
  input  logic [ifht_pkg::OFS_W-1:0]  frag_first_i,
  input  logic [ifht_pkg::OFS_W-1:0]  frag_len_i,
  input  logic                        more_frags_i,
  output ifht_pkg::sts_t              sts_o
);

  localparam int unsigned IW = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
  localparam int unsigned CW = $clog2(MAX_HOLES + 1);
  localparam int unsigned SW = ifht_pkg::START_W;
  localparam int unsigned EW = ifht_pkg::END_W;
  localparam int unsigned OW = ifht_pkg::OFS_W;

  logic [SW-1:0] start_mem [MAX_HOLES];
  logic [EW-1:0] end_mem   [MAX_HOLES];

  logic [MAX_HOLES-1:0] used_q;
  logic [MAX_HOLES-1:0] snap_q;
  logic                 init_q;
  logic                 full_q;
  logic [OW-1:0]        first_q;
  logic [SW-1:0]        last_q;
  logic                 more_q;
  logic [CW-1:0]        rd_idx_q;
  logic                 ev_vld_q;
  logic [IW-1:0]        ev_idx_q;
  logic [SW-1:0]        rd_start_q;
  logic [EW-1:0]        rd_end_q;
  logic                 fresh_q;
  logic [EW-1:0]        rem_end_q;

  logic [SW-1:0] hs;
  logic [EW-1:0] he;
  logic          hit;
  logic          left;
  logic          right;
  logic          rd_more;
  logic          free_found;
  logic [IW-1:0] free_idx;
  logic          we;
  logic [IW-1:0] wa;
  logic [SW-1:0] wstart;
  logic [EW-1:0] wend;

  assign hs = fresh_q ? '0 : rd_start_q;
  assign he = fresh_q ? ifht_pkg::HOLE_INF : rd_end_q;

  always_comb begin
    hit   = cmd_i.scan && ev_vld_q && snap_q[ev_idx_q]
            && !(EW'(first_q) > he) && !(last_q < hs);
    left  = SW'(first_q) > hs;
    right = more_q && (EW'(last_q) < he);
  end

  assign rd_more = (rd_idx_q != CW'(MAX_HOLES));

  // lowest free entry
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < MAX_HOLES; i++) begin
      if (!used_q[i] && !free_found) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  always_comb begin
    we     = 1'b0;
    wa     = ev_idx_q;
    wstart = hs;
    wend   = EW'(first_q) - EW'(1);
    if (cmd_i.split) begin
      we     = free_found;
      wa     = free_idx;
      wstart = last_q + SW'(1);
      wend   = rem_end_q;
    end else if (hit && left) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      start_mem[wa] <= wstart;
      end_mem[wa]   <= wend;
    end
    if (cmd_i.scan && rd_more) begin
      rd_start_q <= start_mem[rd_idx_q[IW-1:0]];
      rd_end_q   <= end_mem[rd_idx_q[IW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      first_q <= frag_first_i;
      last_q  <= SW'(frag_first_i) + SW'(frag_len_i) - SW'(1);
      more_q  <= more_frags_i;
    end
    if (hit) begin
      rem_end_q <= he;
    end
    if (cmd_i.scan && rd_more) begin
      fresh_q <= init_q && (rd_idx_q == '0);
      ev_idx_q <= rd_idx_q[IW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= MAX_HOLES'(1);
      snap_q   <= '0;
      init_q   <= 1'b1;
      full_q   <= 1'b0;
      rd_idx_q <= '0;
      ev_vld_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        full_q   <= 1'b0;
        rd_idx_q <= '0;
        ev_vld_q <= 1'b0;
        if (kind_i == ifht_pkg::KIND_START) begin
          used_q <= MAX_HOLES'(1);
          init_q <= 1'b1;
          snap_q <= '0;
        end else if (frag_len_i == '0) begin
          snap_q <= '0;
        end else begin
          snap_q <= used_q;
        end
      end
      if (cmd_i.scan) begin
        ev_vld_q <= rd_more;
        if (rd_more) begin
          rd_idx_q <= rd_idx_q + CW'(1);
        end
      end
      if (hit) begin
        used_q[ev_idx_q] <= left;
      end
      if (cmd_i.split) begin
        if (free_found) begin
          used_q[free_idx] <= 1'b1;
        end else begin
          full_q <= 1'b1;
        end
      end
      if (we && (wa == '0)) begin
        init_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.need_split  = hit && right;
    sts_o.scan_done   = !ev_vld_q && !rd_more;
    sts_o.more_needed = |used_q;
    sts_o.table_full  = full_q;
  end

endmodule

// ===== rtl/core/ip_fragment_hole_tracker.sv =====
// ip_fragment_hole_tracker: hole descriptor table for one datagram under reassembly
// an accepted item is loaded, then every table entry is scanned, with a split step per split hole, then done_o
// a new item is accepted only while idle, not before the entry scan of the last one has ended
// done_o is a single-cycle strobe; the receiver cannot stall
// reset: table holds the single hole 0..infinity, outputs low, busy low
module ip_fragment_hole_tracker #(
  parameter int unsigned MAX_HOLES = ifht_pkg::MAX_HOLES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        kind_i,
  input  logic [ifht_pkg::OFS_W-1:0]  frag_first_i,
  input  logic [ifht_pkg::OFS_W-1:0]  frag_len_i,
  input  logic                        more_frags_i,
  output logic                        done_o,
  output logic                        more_needed_o,
  output logic                        table_full_o
);

  ifht_pkg::cmd_t cmd;
  ifht_pkg::sts_t sts;

  ifht_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .sts_i         (sts),
    .cmd_o         (cmd),
    .busy_o        (busy),
    .done_o        (done_o),
    .more_needed_o (more_needed_o),
    .table_full_o  (table_full_o)
  );

  ifht_dp #(
    .MAX_HOLES (MAX_HOLES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .kind_i       (kind_i),
    .frag_first_i (frag_first_i),
    .frag_len_i   (frag_len_i),
    .more_frags_i (more_frags_i),
    .sts_o        (sts)
  );

endmodule

// ===== rtl/core/ifht_checker.sv =====
// ifht_checker: port-level assertions for the hole tracker, bound to the top level
// depends on ifht_pkg
module ifht_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic                        kind_i,
  input logic                        done_o,
  input logic                        more_needed_o,
  input logic                        table_full_o
);

  logic kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= ifht_pkg::KIND_FRAG;
    end else if (start && !busy) begin
      kind_q <= kind_i;
    end
  end

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy && $past(busy))
    else $error("result strobe without a finished item");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_start_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (kind_q == ifht_pkg::KIND_START) |-> more_needed_o && !table_full_o)
    else $error("new datagram did not report a single open hole");

  a_full_has_holes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && table_full_o |-> more_needed_o)
    else $error("full table reported with no holes left");

endmodule

bind ip_fragment_hole_tracker ifht_checker u_ifht_checker (.*);
